@@ design/srlm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlm_pkg: shared definitions for the line matcher
// Sizes, character codes, register indexes and the decoded pattern bundle.
// ----------------------------------------------------------------------------
package srlm_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int SLOT_COUNT    = PATTERN_MAX + 1;
  localparam int SLOT_IDX_BITS = $clog2(SLOT_COUNT);
  localparam int PAT_IDX_BITS  = $clog2(PATTERN_MAX);
  localparam int SCAN_LEVELS   = $clog2(SLOT_COUNT);
  localparam int POSITION_BITS = 12;
  localparam int CHAR_BITS     = 8;
  localparam int CFG_WORD_BITS = 64;
  localparam int CFG_IDX_BITS  = 2;
  localparam int LEN_BITS      = 5;

  typedef logic [CHAR_BITS-1:0]     char_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [SLOT_IDX_BITS-1:0] slot_idx_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_WORD_BITS-1:0] cfg_word_t;

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_CARET  = 8'h5E;
  localparam char_t CH_NUL    = 8'h00;

  localparam cfg_idx_t REG_PATTERN_BYTES_LOW  = 2'd0;
  localparam cfg_idx_t REG_PATTERN_BYTES_HIGH = 2'd1;
  localparam cfg_idx_t REG_PATTERN_LENGTH     = 2'd2;

  typedef struct packed {
    logic                          parsing;
    logic                          anchored;
    logic                          at_end;
    slot_idx_t                     count;
    logic [PATTERN_MAX-1:0]        star;
    logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] ch;
  } pat_t;

endpackage

@@ design/srlm_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlm_cfg_if: configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface srlm_cfg_if;
  logic                 valid;
  logic                 ready;
  srlm_pkg::cfg_idx_t   index;
  srlm_pkg::cfg_word_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/srlm_text_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlm_text_if: text character channel
// One beat carries one character or the end-of-line marker.
// ----------------------------------------------------------------------------
interface srlm_text_if;
  logic            valid;
  logic            ready;
  srlm_pkg::char_t text_char;
  logic            end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

@@ design/srlm_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlm_result_if: match result channel
// One beat per line: match flag and leftmost start position.
// ----------------------------------------------------------------------------
interface srlm_result_if;
  logic           valid;
  logic           ready;
  logic           matched;
  srlm_pkg::pos_t match_start;

  modport source (output valid, output matched, output match_start, input ready);
  modport sink   (input valid, input matched, input match_start, output ready);
endinterface

@@ design/simple_regex_line_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_regex_line_matcher: streaming small-regex line matcher
// Matches one line of text, one character per beat, against a pattern of up
// to 16 bytes with ^, $, . and x* and reports the leftmost match start.
// ----------------------------------------------------------------------------
// Text beats are taken at one per clock while no stall holds: every pattern
// position is updated in parallel between the input register and the
// position state, and the end-of-line beat passes through the input register
// and then the result register, while the following line already streams in.
// A pending result that is not taken stalls only the next end-of-line beat.
// After each configuration write the pattern decoder walks the pattern bytes,
// one element per cycle, and holds text ready low while it walks.
module simple_regex_line_matcher (
  input  logic           clk,
  input  logic           rst,
  srlm_cfg_if.sink       cfg,
  srlm_text_if.sink      text,
  srlm_result_if.source  result
);

  srlm_pkg::pat_t pat;

  srlm_parser u_parser (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .pat (pat)
  );

  srlm_nfa u_nfa (
    .clk    (clk),
    .rst    (rst),
    .pat    (pat),
    .text   (text),
    .result (result)
  );

endmodule

@@ design/srlm_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlm_parser: configuration registers and pattern decoder
// Holds the pattern registers and, after every write, walks the raw bytes
// one element per cycle into a compact list of (character, star) elements.
// ----------------------------------------------------------------------------
module srlm_parser (
  input  logic               clk,
  input  logic               rst,
  srlm_cfg_if.sink           cfg,
  output srlm_pkg::pat_t     pat
);

  srlm_pkg::cfg_word_t pat_low;
  srlm_pkg::cfg_word_t pat_high;
  logic [srlm_pkg::LEN_BITS-1:0] pat_len;

  logic parsing;
  logic anchored;
  logic at_end;
  srlm_pkg::slot_idx_t idx;
  srlm_pkg::slot_idx_t count;
  logic [srlm_pkg::PATTERN_MAX-1:0] star;
  logic [srlm_pkg::PATTERN_MAX-1:0][srlm_pkg::CHAR_BITS-1:0] ch;

  logic [srlm_pkg::PATTERN_MAX-1:0][srlm_pkg::CHAR_BITS-1:0] raw;
  logic [srlm_pkg::LEN_BITS-1:0] len_eff;
  srlm_pkg::slot_idx_t idx_p1;
  srlm_pkg::char_t cur;
  srlm_pkg::char_t nxt;
  logic cur_in;
  logic nxt_in;
  logic cfg_fire;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  assign raw     = {pat_high, pat_low};
  assign len_eff = (pat_len > srlm_pkg::LEN_BITS'(srlm_pkg::PATTERN_MAX)) ?
                   srlm_pkg::LEN_BITS'(srlm_pkg::PATTERN_MAX) : pat_len;
  assign idx_p1  = idx + srlm_pkg::SLOT_IDX_BITS'(1);
  assign cur     = raw[idx[srlm_pkg::PAT_IDX_BITS-1:0]];
  assign nxt     = raw[idx_p1[srlm_pkg::PAT_IDX_BITS-1:0]];
  assign cur_in  = (srlm_pkg::LEN_BITS'(idx) < len_eff) && (cur != srlm_pkg::CH_NUL);
  assign nxt_in  = (srlm_pkg::LEN_BITS'(idx_p1) < len_eff) && (nxt != srlm_pkg::CH_NUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= '0;
    end else if (cfg_fire) begin
      case (cfg.index)
        srlm_pkg::REG_PATTERN_BYTES_LOW:  pat_low  <= cfg.data;
        srlm_pkg::REG_PATTERN_BYTES_HIGH: pat_high <= cfg.data;
        srlm_pkg::REG_PATTERN_LENGTH:     pat_len  <= cfg.data[srlm_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // restart the walk on any write
  always_ff @(posedge clk) begin
    if (rst) begin
      parsing  <= 1'b0;
      anchored <= 1'b0;
      at_end   <= 1'b0;
      idx      <= '0;
      count    <= '0;
    end else if (cfg_fire) begin
      parsing  <= 1'b1;
      anchored <= 1'b0;
      at_end   <= 1'b0;
      idx      <= '0;
      count    <= '0;
    end else if (parsing) begin
      if (!cur_in) begin
        parsing <= 1'b0;
      end else if ((idx == '0) && (cur == srlm_pkg::CH_CARET)) begin
        anchored <= 1'b1;
        idx      <= idx_p1;
      end else if (nxt_in && (nxt == srlm_pkg::CH_STAR)) begin
        idx   <= idx + srlm_pkg::SLOT_IDX_BITS'(2);
        count <= count + srlm_pkg::SLOT_IDX_BITS'(1);
      end else if ((cur == srlm_pkg::CH_DOLLAR) && !nxt_in) begin
        at_end <= 1'b1;
        idx    <= idx_p1;
      end else begin
        idx   <= idx_p1;
        count <= count + srlm_pkg::SLOT_IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cfg_fire && parsing && cur_in &&
        !((idx == '0) && (cur == srlm_pkg::CH_CARET)) &&
        !((cur == srlm_pkg::CH_DOLLAR) && !nxt_in && !(nxt_in && (nxt == srlm_pkg::CH_STAR)))) begin
      ch[count[srlm_pkg::PAT_IDX_BITS-1:0]]   <= cur;
      star[count[srlm_pkg::PAT_IDX_BITS-1:0]] <= nxt_in && (nxt == srlm_pkg::CH_STAR);
    end
  end

  always_comb begin
    pat.parsing  = parsing;
    pat.anchored = anchored;
    pat.at_end   = at_end;
    pat.count    = count;
    pat.star     = star;
    pat.ch       = ch;
  end

endmodule

@@ design/srlm_nfa.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlm_nfa: per-character position tracker
// Input register, parallel update of all pattern positions with their
// earliest start, and a result register for the end-of-line beat.
// ----------------------------------------------------------------------------
module srlm_nfa (
  input  logic            clk,
  input  logic            rst,
  input  srlm_pkg::pat_t  pat,
  srlm_text_if.sink       text,
  srlm_result_if.source   result
);

  localparam int NS = srlm_pkg::SLOT_COUNT;
  localparam int NL = srlm_pkg::SCAN_LEVELS;

  logic            ir_valid;
  srlm_pkg::char_t ir_char;
  logic            ir_eot;

  logic [NS-1:0]   act;
  srlm_pkg::pos_t  st [NS];
  srlm_pkg::pos_t  pos;
  logic            found;
  srlm_pkg::pos_t  best;

  logic            out_valid;
  logic            out_matched;
  srlm_pkg::pos_t  out_start;

  logic            out_free;
  logic            step;

  logic [NS-1:0]   av [NL+1];
  logic [NS-1:0]   pv [NL+1];
  srlm_pkg::pos_t  sv [NL+1][NS];
  logic [NS-1:0]   star_ext;
  logic [NS-1:0]   mv;
  logic [NS-1:0]   act_next;
  srlm_pkg::pos_t  st_next [NS];
  srlm_pkg::pos_t  pos_next;
  logic            found_next;
  srlm_pkg::pos_t  best_next;
  logic            fin_act;
  srlm_pkg::pos_t  fin_st;

  assign out_free   = !out_valid || result.ready;
  assign step       = ir_valid && (!ir_eot || out_free);
  assign text.ready = !pat.parsing && (!ir_valid || step);

  assign result.valid       = out_valid;
  assign result.matched     = out_matched;
  assign result.match_start = out_start;

  assign star_ext = {1'b0, pat.star};

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      ir_valid <= 1'b1;
    end else if (step) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      ir_char <= text.text_char;
      ir_eot  <= text.end_of_text;
    end
  end

  // seed the start slot, then close over starred elements by a min scan
  always_comb begin
    av[0] = act;
    for (int i = 0; i < NS; i++) begin
      sv[0][i] = st[i];
    end
    if ((!pat.anchored || (pos == '0)) && (!act[0] || (pos < st[0]))) begin
      av[0][0] = 1'b1;
      sv[0][0] = pos;
    end
    pv[0][0] = 1'b0;
    for (int i = 1; i < NS; i++) begin
      pv[0][i] = (srlm_pkg::SLOT_IDX_BITS'(i - 1) < pat.count) && star_ext[i-1];
    end
    for (int l = 0; l < NL; l++) begin
      for (int i = 0; i < NS; i++) begin
        av[l+1][i] = av[l][i];
        sv[l+1][i] = sv[l][i];
        pv[l+1][i] = 1'b0;
        if (i >= (1 << l)) begin
          pv[l+1][i] = pv[l][i] && pv[l][i-(1<<l)];
          if (pv[l][i] && av[l][i-(1<<l)] &&
              (!av[l][i] || (sv[l][i-(1<<l)] < sv[l][i]))) begin
            av[l+1][i] = 1'b1;
            sv[l+1][i] = sv[l][i-(1<<l)];
          end
        end
      end
    end
  end

  always_comb begin
    fin_act = av[NL][pat.count];
    fin_st  = sv[NL][pat.count];

    found_next = found;
    best_next  = best;
    if (fin_act && (!pat.at_end || ir_eot) && (!found || (fin_st < best))) begin
      found_next = 1'b1;
      best_next  = fin_st;
    end

    mv = '0;
    for (int i = 0; i < srlm_pkg::PATTERN_MAX; i++) begin
      mv[i] = (srlm_pkg::SLOT_IDX_BITS'(i) < pat.count) && av[NL][i] &&
              ((pat.ch[i] == srlm_pkg::CH_DOT) || (pat.ch[i] == ir_char));
    end

    for (int j = 0; j < NS; j++) begin
      act_next[j] = 1'b0;
      st_next[j]  = '0;
      if (mv[j] && star_ext[j]) begin
        act_next[j] = 1'b1;
        st_next[j]  = sv[NL][j];
      end
      if ((j > 0) && mv[j-1] && !star_ext[j-1] &&
          (!act_next[j] || (sv[NL][j-1] < st_next[j]))) begin
        act_next[j] = 1'b1;
        st_next[j]  = sv[NL][j-1];
      end
    end

    pos_next = (pos < srlm_pkg::POS_MAX) ? pos + srlm_pkg::POSITION_BITS'(1) : srlm_pkg::POS_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act   <= '0;
      pos   <= '0;
      found <= 1'b0;
      best  <= '0;
    end else if (step) begin
      if (ir_eot) begin
        act   <= '0;
        pos   <= '0;
        found <= 1'b0;
        best  <= '0;
      end else begin
        act   <= act_next;
        pos   <= pos_next;
        found <= found_next;
        best  <= best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !ir_eot) begin
      for (int j = 0; j < NS; j++) begin
        st[j] <= st_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && ir_eot) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ir_eot) begin
      out_matched <= found_next;
      out_start   <= best_next;
    end
  end

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_matched |-> out_start == '0)
    else $error("no-match result carries a nonzero start");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    step && ir_eot |=> (act == '0) && (pos == '0) && !found)
    else $error("line state not cleared after end of line");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    step && !ir_eot |=> pos != '0)
    else $error("character position failed to advance");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step && ir_eot))
    else $error("result raised without an end-of-line beat");

endmodule
